/* hdl/m3dti_pkg.sv */
package m3dti_pkg;

	localparam int ENTRY_W   = 32;
	localparam int FRAC_BITS = 16;
	localparam int N_ENTRY   = 9;

	// Exact widths of the intermediate values.
	localparam int PROD_W = 2 * ENTRY_W;
	localparam int COF_W  = PROD_W + 1;
	localparam int DET_W  = ENTRY_W + COF_W;
	localparam int LO_W   = ENTRY_W + 1;
	localparam int MAG_W  = DET_W;
	localparam int QW     = ENTRY_W + 2;
	localparam int CMP_W  = MAG_W + QW - 1;
	localparam int SAT_W  = COF_W + 1;
	localparam int DIV_LAT = QW + 2;

	localparam int IN_DATA_W  = N_ENTRY * ENTRY_W;
	localparam int OUT_DATA_W = (N_ENTRY + 1) * ENTRY_W;

	localparam logic [1:0] OP_DET   = 2'd0;
	localparam logic [1:0] OP_TRACE = 2'd1;
	localparam logic [1:0] OP_INV   = 2'd2;
	localparam logic [1:0] OP_RSVD  = 2'd3;

	typedef logic signed [ENTRY_W-1:0] entry_t;
	typedef logic signed [COF_W-1:0] cof_t;
	typedef logic signed [DET_W-1:0] det_t;

	localparam logic signed [SAT_W-1:0] E_MAX = SAT_W'((64'd1 << (ENTRY_W - 1)) - 64'd1);
	localparam logic signed [SAT_W-1:0] E_MIN = ~E_MAX;

	function automatic entry_t sat_entry(input logic signed [SAT_W-1:0] v);
		entry_t r;
		if (v > E_MAX) begin
			r = E_MAX[ENTRY_W-1:0];
		end else if (v < E_MIN) begin
			r = E_MIN[ENTRY_W-1:0];
		end else begin
			r = v[ENTRY_W-1:0];
		end
		return r;
	endfunction

endpackage

/* hdl/m3dti_div.sv */
module m3dti_div (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic signed [m3dti_pkg::COF_W-1:0]     cof,
	input  logic signed [m3dti_pkg::DET_W-1:0]     det,
	output m3dti_pkg::entry_t                      res
);
	import m3dti_pkg::*;

	logic [COF_W-1:0] cof_abs;
	logic [DET_W-1:0] det_abs;
	logic [MAG_W-1:0] num_c;
	logic [MAG_W-1:0] den_c;

	logic [MAG_W-1:0] rem_s [0:QW];
	logic [MAG_W-1:0] den_s [0:QW];
	logic [QW-1:0]    quo_s [0:QW];
	logic             neg_s [0:QW];

	logic signed [SAT_W-1:0] quo_signed;
	entry_t res_q;

	// Rounded magnitude quotient is floor((|n| * 2^33 + |d|) / (2|d|)).
	always_comb begin
		cof_abs = cof[COF_W-1] ? COF_W'(-cof) : COF_W'(cof);
		det_abs = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
		num_c   = (MAG_W'(cof_abs) << (2 * FRAC_BITS + 1)) + MAG_W'(det_abs);
		den_c   = {det_abs[MAG_W-2:0], 1'b0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num_c;
			den_s[0] <= den_c;
			quo_s[0] <= '0;
			neg_s[0] <= cof[COF_W-1] ^ det[DET_W-1];
		end
	end

	// One quotient bit per stage, top bit first. A set top bit means the
	// result saturates, whatever the lower bits hold.
	for (genvar i = 1; i <= QW; i++) begin : g_bit
		logic [CMP_W-1:0] dsh;
		logic             ge;
		logic [QW-1:0]    qn;
		always_comb begin
			dsh = CMP_W'(den_s[i-1]) << (QW - i);
			ge  = CMP_W'(rem_s[i-1]) >= dsh;
			qn  = quo_s[i-1];
			qn[QW-i] = ge;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? rem_s[i-1] - dsh[MAG_W-1:0] : rem_s[i-1];
				den_s[i] <= den_s[i-1];
				quo_s[i] <= qn;
				neg_s[i] <= neg_s[i-1];
			end
		end
	end

	always_comb begin
		quo_signed = neg_s[QW] ? -SAT_W'(quo_s[QW]) : SAT_W'(quo_s[QW]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= sat_entry(quo_signed);
		end
	end

	assign res = res_q;

endmodule

/* hdl/matrix3x3_det_trace_inverse_core.sv */
// Streaming 3x3 determinant, trace and inverse on signed Q16.16 entries. One item
// is accepted every cycle while the output side keeps up; each item passes through
// five stages of products, cofactors and the determinant sum, 36 stages of the nine
// bit-per-stage dividers and one output register. The dividers make one quotient bit
// per stage. A stall on the output holds the whole pipeline. Unless the operation is
// the reserved one, a singular matrix gives a zero inverse and the singular flag.
module matrix3x3_det_trace_inverse_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// a_xx, a_xy, a_xz, a_yx, a_yy, a_yz, a_zx, a_zy, a_zz
	input  logic [m3dti_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// operation
	input  logic [1:0]                            s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// r_xx, r_xy, r_xz, r_yx, r_yy, r_yz, r_zx, r_zy, r_zz, scalar_result
	output logic [m3dti_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// singular
	output logic [0:0]                            m_axis_tuser
);
	import m3dti_pkg::*;

	typedef struct packed {
		logic [1:0] op;
		entry_t     trace;
		entry_t     det_sc;
		logic       sing;
	} side_t;

	logic en;
	entry_t ent [N_ENTRY];
	logic signed [ENTRY_W+1:0] trace_sum;

	logic signed [PROD_W-1:0] pa_s1 [N_ENTRY];
	logic signed [PROD_W-1:0] pb_s1 [N_ENTRY];
	entry_t     row_s1 [3];
	logic [1:0] op_s1;
	entry_t     trace_s1;
	logic       vld_s1;

	cof_t       cof_s2 [N_ENTRY];
	entry_t     row_s2 [3];
	logic [1:0] op_s2;
	entry_t     trace_s2;
	logic       vld_s2;

	logic signed [LO_W+ENTRY_W:0]  pl_s3 [3];
	logic signed [PROD_W-1:0]      ph_s3 [3];
	cof_t       cof_s3 [N_ENTRY];
	logic [1:0] op_s3;
	entry_t     trace_s3;
	logic       vld_s3;

	det_t       term_s4 [3];
	cof_t       cof_s4 [N_ENTRY];
	logic [1:0] op_s4;
	entry_t     trace_s4;
	logic       vld_s4;

	det_t       det_s5;
	cof_t       cof_s5 [N_ENTRY];
	logic [1:0] op_s5;
	entry_t     trace_s5;
	logic       vld_s5;

	logic [DET_W-1:0] det_mag;
	logic [DET_W-1:0] det_rsum;
	logic signed [SAT_W-1:0] det_rnd;
	side_t side_in;
	side_t side_d [DIV_LAT];
	logic  vld_d  [DIV_LAT];
	side_t sd;

	entry_t div_res [N_ENTRY];
	logic [OUT_DATA_W-1:0] out_data;
	logic                  out_sing;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic [0:0]            m_user_q;
	logic                  m_valid_q;

	assign en = !m_valid_q || m_axis_tready;
	assign s_axis_tready = en;

	always_comb begin
		for (int k = 0; k < N_ENTRY; k++) begin
			ent[k] = s_axis_tdata[k*ENTRY_W +: ENTRY_W];
		end
		trace_sum = (ENTRY_W+2)'(ent[0]) + (ENTRY_W+2)'(ent[4]) + (ENTRY_W+2)'(ent[8]);
	end

	// Stage 1: the two products of every cofactor.
	for (genvar i = 0; i < 3; i++) begin : g_ci
		for (genvar j = 0; j < 3; j++) begin : g_cj
			localparam int I1 = (i + 1) % 3;
			localparam int I2 = (i + 2) % 3;
			localparam int J1 = (j + 1) % 3;
			localparam int J2 = (j + 2) % 3;
			always_ff @(posedge clk) begin
				if (en) begin
					pa_s1[i*3+j] <= ent[I1*3+J1] * ent[I2*3+J2];
					pb_s1[i*3+j] <= ent[I1*3+J2] * ent[I2*3+J1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				row_s1[k] <= ent[k];
			end
			op_s1    <= s_axis_tuser;
			trace_s1 <= sat_entry(SAT_W'(trace_sum));
		end
	end

	// Stage 2: cofactors. Stage 3: first row times each of its cofactors, split in halves.
	// Stage 4: recombined terms. Stage 5: determinant.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N_ENTRY; k++) begin
				cof_s2[k] <= COF_W'(pa_s1[k]) - COF_W'(pb_s1[k]);
				cof_s3[k] <= cof_s2[k];
				cof_s4[k] <= cof_s3[k];
				cof_s5[k] <= cof_s4[k];
			end
			for (int k = 0; k < 3; k++) begin
				row_s2[k]  <= row_s1[k];
				pl_s3[k]   <= row_s2[k] * $signed({1'b0, cof_s2[k][LO_W-1:0]});
				ph_s3[k]   <= row_s2[k] * $signed(cof_s2[k][COF_W-1:LO_W]);
				term_s4[k] <= (DET_W'(ph_s3[k]) <<< LO_W) + DET_W'(pl_s3[k]);
			end
			det_s5   <= term_s4[0] + term_s4[1] + term_s4[2];
			op_s2    <= op_s1;
			op_s3    <= op_s2;
			op_s4    <= op_s3;
			op_s5    <= op_s4;
			trace_s2 <= trace_s1;
			trace_s3 <= trace_s2;
			trace_s4 <= trace_s3;
			trace_s5 <= trace_s4;
		end
	end

	// Determinant over the square of the scale: a rounded shift.
	always_comb begin
		det_mag  = det_s5[DET_W-1] ? DET_W'(-det_s5) : DET_W'(det_s5);
		det_rsum = det_mag + (DET_W'(1) << (2 * FRAC_BITS - 1));
		det_rnd  = SAT_W'(det_rsum >> (2 * FRAC_BITS));
		if (det_s5[DET_W-1]) begin
			det_rnd = -det_rnd;
		end
		side_in.op     = op_s5;
		side_in.trace  = trace_s5;
		side_in.det_sc = sat_entry(det_rnd);
		side_in.sing   = (det_s5 == '0);
	end

	// Inverse entry (i, j) is cofactor (j, i) over the determinant.
	for (genvar i = 0; i < 3; i++) begin : g_di
		for (genvar j = 0; j < 3; j++) begin : g_dj
			m3dti_div u_div (
				.clk (clk),
				.en  (en),
				.cof (cof_s5[j*3+i]),
				.det (det_s5),
				.res (div_res[i*3+j])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_d[0] <= side_in;
			for (int k = 1; k < DIV_LAT; k++) begin
				side_d[k] <= side_d[k-1];
			end
		end
	end

	always_comb begin
		sd = side_d[DIV_LAT-1];
		out_data = '0;
		out_sing = 1'b0;
		case (sd.op)
			OP_DET: begin
				out_data[N_ENTRY*ENTRY_W +: ENTRY_W] = sd.det_sc;
				out_sing = sd.sing;
			end
			OP_TRACE: begin
				out_data[N_ENTRY*ENTRY_W +: ENTRY_W] = sd.trace;
				out_sing = sd.sing;
			end
			OP_INV: begin
				out_sing = sd.sing;
				if (!sd.sing) begin
					out_data[N_ENTRY*ENTRY_W +: ENTRY_W] = sd.det_sc;
					for (int k = 0; k < N_ENTRY; k++) begin
						out_data[k*ENTRY_W +: ENTRY_W] = div_res[k];
					end
				end
			end
			default: begin
				out_data = '0;
				out_sing = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			for (int k = 0; k < DIV_LAT; k++) begin
				vld_d[k] <= 1'b0;
			end
			m_valid_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= s_axis_tvalid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			vld_d[0]  <= vld_s5;
			for (int k = 1; k < DIV_LAT; k++) begin
				vld_d[k] <= vld_d[k-1];
			end
			m_valid_q <= vld_d[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_data_q <= out_data;
			m_user_q <= out_sing;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	a_sing_zero_inv: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_user_q[0] |-> m_data_q[N_ENTRY*ENTRY_W-1:0] == '0)
		else $error("singular item carries a nonzero inverse");

	a_pipe_exit: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_d[DIV_LAT-1] |=> m_valid_q)
		else $error("item leaving the divider pipeline was dropped");

	a_rsvd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_d[DIV_LAT-1] && side_d[DIV_LAT-1].op == OP_RSVD
		|=> m_data_q == '0 && m_user_q == '0)
		else $error("unused operation code gave a nonzero result");

endmodule
